// File: rtl/core/egbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types, constants and helpers of the Exp-Golomb bit writer.
// ----------------------------------------------------------------------------
package egbw_pkg;

  localparam int unsigned MAX_FIELD_BITS = 32;   // longest fixed field
  localparam int unsigned VAL_W          = 32;   // fixed field / ue value width
  localparam int unsigned CODE_W         = 31;   // code number + 1
  localparam int unsigned TOK_W          = 64;   // left-aligned token bits
  localparam int unsigned NB_W           = 7;    // token bit count, up to 61
  localparam int unsigned POS_W          = 5;    // msb position within CODE_W
  localparam int unsigned CNT_W          = 6;    // fixed field count width
  localparam int unsigned SR_W           = TOK_W + 8;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Largest code number plus one (code number saturates at 2^31-2).
  localparam logic [CODE_W-1:0] CODE_MAX  = 31'h7FFF_FFFF;
  // Most negative signed value, whose mapped code saturates.
  localparam logic [CODE_W-1:0] SE_MIN    = 31'h4000_0000;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_UE    = 2'd1,
    KIND_SE    = 2'd2,
    KIND_TRAIL = 2'd3
  } kind_e;

  // Bits of one syntax element, first bit at the msb of bits.
  typedef struct packed {
    logic [TOK_W-1:0] bits;
    logic [NB_W-1:0]  nbits;
    logic             trail;   // pad to byte boundary, length set by packer
  } token_t;

  // Position of the highest set bit (zero when no bit is set).
  function automatic logic [POS_W-1:0] msb_pos(input logic [CODE_W-1:0] x);
    logic [(1 << POS_W)-1:0] v;
    logic [POS_W-1:0]        p;
    v = {{((1 << POS_W) - CODE_W){1'b0}}, x};
    p = '0;
    for (int k = POS_W - 1; k >= 0; k--) begin
      if ((v >> (1 << k)) != '0) begin
        p[k] = 1'b1;
        v    = v >> (1 << k);
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/egbw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbw_front
// Accepts syntax elements, maps them to code numbers and builds left-aligned
// bit tokens for the packer.
// ----------------------------------------------------------------------------
module egbw_front import egbw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic [VAL_W-1:0]        uvalue_i,
  input  logic signed [CODE_W-1:0] svalue_i,
  input  logic [CNT_W-1:0]        count_i,
  output logic                    tok_valid_o,
  input  logic                    tok_ready_i,
  output token_t                  tok_o
);

  logic              s1_valid_q, s1_valid_d;
  kind_e             kind_q;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  cnt_q, cnt_sat;
  logic              push, accept;

  logic [VAL_W-1:0]  mask;
  logic [CODE_W-1:0] sraw, mag, ue_c, se_c;
  logic [POS_W-1:0]  pos;

  assign push        = s1_valid_q && tok_ready_i;
  assign in_ready_o  = !s1_valid_q || push;
  assign accept      = in_valid_i && in_ready_o;
  assign tok_valid_o = s1_valid_q;

  // Stage 1: classify, mask and map to code number plus one.
  always_comb begin
    cnt_sat = (count_i > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : count_i;
    mask    = ~({VAL_W{1'b1}} << cnt_sat);
    sraw    = svalue_i;
    mag     = CODE_W'({1'b1, {CODE_W{1'b0}}} - {1'b0, sraw});
    ue_c    = (uvalue_i >= {1'b0, CODE_MAX}) ? CODE_MAX : CODE_W'(uvalue_i + 32'd1);
    if (sraw == '0) begin
      se_c = CODE_W'(1);
    end else if (!sraw[CODE_W-1]) begin
      se_c = {sraw[CODE_W-2:0], 1'b0};
    end else if (sraw == SE_MIN) begin
      se_c = CODE_MAX;
    end else begin
      se_c = {mag[CODE_W-2:0], 1'b1};
    end
    case (kind_e'(kind_i))
      KIND_FIXED: val_d = uvalue_i & mask;
      KIND_UE:    val_d = {1'b0, ue_c};
      KIND_SE:    val_d = {1'b0, se_c};
      default:    val_d = '0;
    endcase
    s1_valid_d = accept ? 1'b1 : (push ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      val_q  <= val_d;
      cnt_q  <= cnt_sat;
    end
  end

  // Stage 2: left-align the code word. ue/se: c written in 2*len-1 bits.
  always_comb begin
    pos = msb_pos(val_q[CODE_W-1:0]);
    tok_o.trail = 1'b0;
    case (kind_q)
      KIND_FIXED: begin
        tok_o.bits  = {val_q, {(TOK_W-VAL_W){1'b0}}} << (CNT_W'(VAL_W) - cnt_q);
        tok_o.nbits = NB_W'(cnt_q);
      end
      KIND_UE, KIND_SE: begin
        tok_o.bits  = TOK_W'(val_q[CODE_W-1:0]) << (6'(TOK_W - 1) - {pos, 1'b0});
        tok_o.nbits = NB_W'({pos, 1'b1});
      end
      default: begin
        tok_o.bits  = {1'b1, {(TOK_W-1){1'b0}}};
        tok_o.nbits = '0;
        tok_o.trail = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/egbw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbw_queue
// Short token queue between the encoder front and the byte packer.
// ----------------------------------------------------------------------------
module egbw_queue import egbw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   ready_o,
  input  token_t data_i,
  output logic   valid_o,
  input  logic   pop_i,
  output token_t data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  token_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/egbw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egbw_back
// Byte packer: merges tokens behind the partial byte and emits one completed
// byte per beat, marking the last byte of each element.
// ----------------------------------------------------------------------------
module egbw_back import egbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_valid_i,
  output logic        tok_pop_o,
  input  token_t      tok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic [SR_W-1:0] sr_q, sr_d, sr_a;
  logic [NB_W-1:0] rem_q, rem_d, rem_a, n_eff;
  logic [2:0]      fill;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            last_q;
  logic            out_free, emit, load;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (rem_q[NB_W-1:3] != '0) && out_free;

  always_comb begin
    sr_a  = emit ? (sr_q << 8) : sr_q;
    rem_a = emit ? (rem_q - NB_W'(8)) : rem_q;
    fill  = rem_a[2:0];
    load  = (rem_a[NB_W-1:3] == '0) && tok_valid_i;
    // Trailing bits: the one bit plus zeros up to the byte boundary.
    n_eff = tok_i.trail ? NB_W'(4'd8 - {1'b0, fill}) : tok_i.nbits;
    sr_d  = sr_a;
    rem_d = rem_a;
    if (load) begin
      sr_d  = sr_a | ({tok_i.bits, 8'h00} >> fill);
      rem_d = rem_a + n_eff;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign tok_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sr_q        <= sr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Last byte of an element: fewer than eight bits remain behind it.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= sr_q[SR_W-1 -: 8];
      last_q     <= (rem_q[NB_W-1:3] == 4'd1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= NB_W'(68))
    else $error("packer bit count out of range");

  a_clean_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sr_q << rem_q) == '0)
    else $error("stray bits behind the valid packer bits");

  a_load_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> rem_q < NB_W'(16))
    else $error("token merged while whole bytes are pending");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rem_q[NB_W-1:3] == 4'd1) && !load) |=> rem_q < NB_W'(8))
    else $error("bytes left after the last byte of an element");
`endif

endmodule

// File: rtl/core/exp_golomb_bit_writer_unit.sv
`timescale 1ns / 1ps
// Path: front stage register, token queue, packer bit register, output byte register.
// Throughput (no output stall): one element per cycle while each completes at most one
//   byte; an element with more bytes holds the byte packer (one output byte a cycle).
// Reset: rst_ni clears the partial byte to empty (byte aligned) and empties the queue.
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_unit
// H.264-style bitstream writer: fixed fields, ue(v), se(v) and trailing bits,
// packed msb first into bytes.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_unit import egbw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic [VAL_W-1:0]         uvalue_i,
  input  logic signed [CODE_W-1:0] svalue_i,
  input  logic [CNT_W-1:0]         count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     last_o
);

  token_t fr_tok, q_tok;
  logic   fr_valid, q_ready, q_valid, q_pop;

  egbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .uvalue_i    (uvalue_i),
    .svalue_i    (svalue_i),
    .count_i     (count_i),
    .tok_valid_o (fr_valid),
    .tok_ready_i (q_ready),
    .tok_o       (fr_tok)
  );

  egbw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .ready_o (q_ready),
    .data_i  (fr_tok),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_tok)
  );

  egbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_pop_o   (q_pop),
    .tok_i       (q_tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// File: tb/exp_golomb_bit_writer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_unit_checker
// Watches the element and byte channels of the bit writer. Each accepted
// element is coded here into stream bits, which are packed msb first into
// expected bytes. Each accepted byte beat is then compared with the oldest
// expected byte and its last flag.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_unit_checker import egbw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [VAL_W-1:0]    uvalue_i,
  input  logic [CODE_W-1:0]   svalue_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          out_byte_i,
  input  logic                last_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o,
  output int unsigned         elements_o,
  output int unsigned         bytes_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t expected_bytes[$];
  logic [7:0]   pack_byte;
  logic [2:0]   pack_fill;
  int unsigned  mismatch_cnt;
  int unsigned  element_cnt;
  int unsigned  byte_cnt;

  // Exp-Golomb bits of a code number: len-1 zeros, then code+1 in len bits.
  // The zeros are just the upper part of a right-aligned 2*len-1 bit field.
  function automatic void golomb_bits(input logic [63:0] code_val,
                                      output logic [63:0] bits,
                                      output int nbits);
    logic [63:0] c;
    int          len;
    if (code_val > 64'h7FFF_FFFE) code_val = 64'h7FFF_FFFE;
    c   = code_val + 64'd1;
    len = 0;
    for (int k = 0; k < 64; k++) begin
      if (c[k]) len = k + 1;
    end
    bits  = c;
    nbits = 2 * len - 1;
  endfunction

  task automatic encode_element(input logic [1:0] kind, input logic [31:0] uval,
                                input logic [30:0] sval, input logic [5:0] cnt);
    logic [63:0]  bits;
    int           nbits;
    logic [63:0]  mag;
    logic [7:0]   done_bytes[$];
    stream_byte_t entry;
    bits  = '0;
    nbits = 0;
    case (kind_e'(kind))
      KIND_FIXED: begin
        nbits = (cnt > MAX_FIELD_BITS) ? int'(MAX_FIELD_BITS) : int'(cnt);
        bits  = {32'd0, uval};
      end
      KIND_UE: golomb_bits({32'd0, uval}, bits, nbits);
      KIND_SE: begin
        // map v > 0 to 2v-1 and v <= 0 to -2v
        if (sval[30]) begin
          mag = 64'h8000_0000 - {33'd0, sval};
          golomb_bits(2 * mag, bits, nbits);
        end else if (sval == '0) begin
          golomb_bits(64'd0, bits, nbits);
        end else begin
          golomb_bits(2 * {33'd0, sval} - 64'd1, bits, nbits);
        end
      end
      default: begin
        // stop bit, then zeros up to the byte boundary
        nbits = (pack_fill == 3'd7) ? 1 : 8 - int'(pack_fill);
        bits  = 64'd1 << (nbits - 1);
      end
    endcase
    for (int k = nbits - 1; k >= 0; k--) begin
      pack_byte = {pack_byte[6:0], bits[k]};
      pack_fill = pack_fill + 3'd1;
      if (pack_fill == 3'd0) done_bytes.push_back(pack_byte);
    end
    foreach (done_bytes[k]) begin
      entry.data = done_bytes[k];
      entry.last = (k == done_bytes.size() - 1);
      expected_bytes.push_back(entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    stream_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      pack_byte    = '0;
      pack_fill    = '0;
      mismatch_cnt = 0;
      element_cnt  = 0;
      byte_cnt     = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        encode_element(kind_i, uvalue_i, svalue_i, count_i);
        element_cnt++;
      end
      if (out_valid_i && out_ready_i) begin
        byte_cnt++;
        if (expected_bytes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected byte %02h last %0b, nothing pending",
                     $time, out_byte_i, last_i);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_i !== want.data || last_i !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: byte %0d expected %02h last %0b, got %02h last %0b",
                       $time, byte_cnt, want.data, want.last, out_byte_i, last_i);
          end
        end
      end
    end
    pending_o  <= expected_bytes.size();
    errors_o   <= mismatch_cnt;
    elements_o <= element_cnt;
    bytes_o    <= byte_cnt;
  end

endmodule

// File: tb/exp_golomb_bit_writer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_unit_tb
// Drives fixed fields, ue(v), se(v) and trailing-bit elements into the bit
// writer with random gaps and output stalls; the checker beside the block
// predicts the byte stream and counts mismatches.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_unit_tb;
  import egbw_pkg::*;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CALM_ITEMS  = 60;
  localparam int unsigned BURST_ITEMS = 40;
  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN       = 16;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  kind_e             kind      = KIND_FIXED;
  logic [VAL_W-1:0]  uvalue    = '0;
  logic [CODE_W-1:0] svalue    = '0;
  logic [CNT_W-1:0]  count     = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_byte;
  logic              last;

  logic              calm      = 1'b0;  // no gaps on either side
  logic              hold_req  = 1'b0;
  logic              hold_done = 1'b0;
  int unsigned       pending;
  int unsigned       errors;
  int unsigned       elements;
  int unsigned       bytes_seen;

  exp_golomb_bit_writer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .uvalue_i    (uvalue),
    .svalue_i    (svalue),
    .count_i     (count),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .last_o      (last)
  );

  exp_golomb_bit_writer_unit_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .kind_i      (kind),
    .uvalue_i    (uvalue),
    .svalue_i    (svalue),
    .count_i     (count),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_byte_i  (out_byte),
    .last_i      (last),
    .pending_o   (pending),
    .errors_o    (errors),
    .elements_o  (elements),
    .bytes_o     (bytes_seen)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d bytes still pending", CYCLE_LIMIT, pending);
    $display("status: fail");
    $finish;
  end

  // Byte sink: random stall before each beat, one long hold-off on request.
  initial begin : byte_sink
    int unsigned gap;
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_element(input kind_e k, input logic [31:0] uv,
                              input logic [30:0] sv, input logic [5:0] cnt);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    uvalue   <= uv;
    svalue   <= sv;
    count    <= cnt;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random_element();
    kind_e       k;
    logic [31:0] uv;
    logic [30:0] sv;
    logic [5:0]  cnt;
    int          s;
    int unsigned pick;
    uv   = $urandom();
    sv   = 31'($urandom());
    cnt  = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k = KIND_FIXED;
      if ($urandom_range(0, 9) != 0) cnt = 6'($urandom_range(1, 32));
    end else if (pick < 60) begin
      k = KIND_UE;
      case ($urandom_range(0, 3))
        0: uv = $urandom_range(0, 40);
        1: uv = uv >> $urandom_range(0, 31);
        2: ;
        default: uv = 32'h7FFF_FFFD + $urandom_range(0, 3);
      endcase
    end else if (pick < 90) begin
      k = KIND_SE;
      case ($urandom_range(0, 3))
        0: begin
          s  = int'($urandom_range(0, 40)) - 20;
          sv = s[30:0];
        end
        1: begin
          s = int'($urandom() >> $urandom_range(2, 31));
          if ($urandom_range(0, 1) != 0) s = -s;
          sv = s[30:0];
        end
        2: ;
        default: begin
          // both ends of the signed range, the most negative one included
          case ($urandom_range(0, 3))
            0: sv = 31'h3FFF_FFFF;
            1: sv = 31'h4000_0000;
            2: sv = 31'h4000_0001;
            default: sv = 31'h7FFF_FFFF;
          endcase
        end
      endcase
    end else begin
      k = KIND_TRAIL;
    end
    send_element(k, uv, sv, cnt);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fixed fields: empty, byte, full width, oversized count, masked value
    send_element(KIND_FIXED, 32'hFFFF_FFFF, '0, 6'd0);
    send_element(KIND_FIXED, 32'h0000_00A5, '0, 6'd8);
    send_element(KIND_FIXED, 32'hDEAD_BEEF, '0, 6'd32);
    send_element(KIND_FIXED, 32'h1234_5678, '0, 6'd63);
    send_element(KIND_FIXED, 32'hFFFF_FFF5, '0, 6'd3);
    // ue(v): smallest codes, largest code, saturation
    send_element(KIND_UE, 32'd0, '0, '0);
    send_element(KIND_UE, 32'd1, '0, '0);
    send_element(KIND_UE, 32'd2, '0, '0);
    send_element(KIND_UE, 32'h7FFF_FFFE, '0, '0);
    send_element(KIND_UE, 32'hFFFF_FFFF, '0, '0);
    // se(v): zero, +-1, both range ends, saturating most negative value
    send_element(KIND_SE, '0, 31'h0000_0000, '0);
    send_element(KIND_SE, '0, 31'h0000_0001, '0);
    send_element(KIND_SE, '0, 31'h7FFF_FFFF, '0);
    send_element(KIND_SE, '0, 31'h3FFF_FFFF, '0);
    send_element(KIND_SE, '0, 31'h4000_0001, '0);
    send_element(KIND_SE, '0, 31'h4000_0000, '0);
    // trailing bits: unaligned, stop bit lands on the boundary, aligned
    send_element(KIND_TRAIL, '0, '0, '0);
    send_element(KIND_FIXED, 32'h0000_0055, '0, 6'd7);
    send_element(KIND_TRAIL, '0, '0, '0);
    send_element(KIND_TRAIL, '0, '0, '0);
    send_element(KIND_FIXED, 32'h0000_0001, '0, 6'd1);

    calm <= 1'b1;
    repeat (CALM_ITEMS) send_random_element();

    // stall the byte side while elements keep coming back to back
    hold_req <= 1'b1;
    repeat (BURST_ITEMS) send_random_element();
    calm <= 1'b0;

    // hold the element side until the stream has drained
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    repeat (RAND_ITEMS) send_random_element();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d elements of all four kinds, %0d bytes checked, %0d mismatches",
             elements, bytes_seen, errors);
    $display("output held off once for %0d cycles under back-to-back input", HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
